// ===== rtl/dalru_pkg.sv =====
// Shared types and constants for the dirty-aware LRU victim select unit.
package dalru_pkg;

  localparam int MaskW   = 8;
  localparam int ThreshW = 4;
  localparam int SetIdxW = 6;
  localparam int WayIdxW = 3;

  localparam logic [ThreshW-1:0] ThreshReset = 4'd8;

  typedef enum logic {
    CMD_VICTIM = 1'b0,
    CMD_TOUCH  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e               command;
    logic [SetIdxW-1:0] set_index;
    logic [WayIdxW-1:0] touch_way;
    logic [MaskW-1:0]   valid_mask;
    logic [MaskW-1:0]   dirty_mask;
    logic [MaskW-1:0]   protected_mask;
  } item_t;

  typedef struct packed {
    logic [WayIdxW-1:0] victim_way;
    logic               threshold_event;
    logic [SetIdxW-1:0] event_set;
  } result_t;

endpackage

// ===== rtl/dalru_age_mem.sv =====
// Per-set LRU age storage with a clearing sweep after reset.
module dalru_age_mem
  import dalru_pkg::*;
#(
  parameter int SETS  = 64,
  parameter int ROW_W = 24,
  localparam int SetW = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ROW_W-1:0] init_row_i,
  input  logic [SetW-1:0]  rd_addr_i,
  output logic [ROW_W-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [SetW-1:0]  wr_addr_i,
  input  logic [ROW_W-1:0] wr_data_i,
  output logic             clearing_o
);

  logic [ROW_W-1:0] mem [SETS];
  logic [ROW_W-1:0] rd_data_q;
  logic             clr_q, clr_d;
  logic [SetW-1:0]  clr_cnt_q, clr_cnt_d;
  logic             we;
  logic [SetW-1:0]  wa;
  logic [ROW_W-1:0] wd;

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == SetW'(SETS - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // sweep owns the write port until every row holds the reset permutation
  assign we = clr_q | wr_en_i;
  assign wa = clr_q ? clr_cnt_q : wr_addr_i;
  assign wd = clr_q ? init_row_i : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clr_q;

endmodule

// ===== rtl/dalru_select.sv =====
// Victim choice and LRU age update for one set.
module dalru_select
  import dalru_pkg::*;
#(
  parameter int WAYS  = 8,
  localparam int AgeW = $clog2(WAYS),
  localparam int RowW = WAYS * AgeW
) (
  input  item_t              item_i,
  input  logic [SetIdxW-1:0] set_i,
  input  logic [ThreshW-1:0] thresh_i,
  input  logic [RowW-1:0]    ages_i,
  output result_t            result_o,
  output logic [RowW-1:0]    ages_o
);

  localparam int WayW = AgeW;

  logic [AgeW-1:0] age [WAYS];
  logic [WAYS-1:0] vld, dty, prt, win;
  logic [WayW-1:0] first_inv, oldest, ord_way, victim, mru_way;
  logic            inv_any, hit, do_mru, evt;
  logic            f_inv, f_old, f_ord;
  logic [4:0]      ndirty;
  logic [AgeW-1:0] cur;

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    assign age[w] = ages_i[w*AgeW +: AgeW];
    if (w < MaskW) begin : g_mask
      assign vld[w] = item_i.valid_mask[w];
      assign dty[w] = item_i.dirty_mask[w];
      assign prt[w] = item_i.protected_mask[w];
    end else begin : g_nomask
      assign vld[w] = 1'b0;
      assign dty[w] = 1'b0;
      assign prt[w] = 1'b0;
    end
  end

  always_comb begin
    first_inv = '0;
    oldest    = '0;
    ord_way   = '0;
    f_inv     = 1'b0;
    f_old     = 1'b0;
    f_ord     = 1'b0;
    // ages are a permutation, so the oldest unprotected way beats every other one
    for (int w = 0; w < WAYS; w++) begin
      win[w] = !prt[w] && (age[w] != '0);
      for (int v = 0; v < WAYS; v++) begin
        if (v != w && !prt[v] && !(age[v] < age[w])) begin
          win[w] = 1'b0;
        end
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!vld[w] && !f_inv) begin
        first_inv = WayW'(w);
        f_inv     = 1'b1;
      end
      if ((age[w] == AgeW'(WAYS - 1)) && !f_old) begin
        oldest = WayW'(w);
        f_old  = 1'b1;
      end
      if (win[w] && !f_ord) begin
        ord_way = WayW'(w);
        f_ord   = 1'b1;
      end
    end
  end

  assign inv_any = ~&vld;
  assign ndirty  = 5'($countones(dty));
  assign hit     = ndirty >= {1'b0, thresh_i};

  always_comb begin
    victim  = '0;
    mru_way = '0;
    do_mru  = 1'b0;
    evt     = 1'b0;
    if (item_i.command == CMD_TOUCH) begin
      mru_way = WayW'(item_i.touch_way);
      do_mru  = int'(item_i.touch_way) < WAYS;
    end else if (inv_any) begin
      victim  = first_inv;
      mru_way = first_inv;
      do_mru  = 1'b1;
    end else if (hit) begin
      victim  = oldest;
      evt     = 1'b1;
    end else begin
      victim  = ord_way;
      mru_way = ord_way;
      do_mru  = 1'b1;
    end
  end

  assign cur = age[mru_way];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      ages_o[w*AgeW +: AgeW] = age[w];
      if (do_mru) begin
        if (WayW'(w) == mru_way) begin
          ages_o[w*AgeW +: AgeW] = '0;
        end else if (age[w] < cur) begin
          ages_o[w*AgeW +: AgeW] = age[w] + 1'b1;
        end
      end
    end
  end

  assign result_o.victim_way      = WayIdxW'(victim);
  assign result_o.threshold_event = evt;
  assign result_o.event_set       = set_i;

endmodule

// ===== rtl/dirty_aware_lru_victim_select_unit.sv =====
// Top level of the dirty-aware LRU victim select unit.
//
// Takes one command per cycle (start high while busy is low). A touch makes a
// way most recently used and returns nothing. A victim command returns one
// result, strobed by result_valid_o for a single cycle once the command has
// moved through the select stage register and the result register. The
// set's ages are read from a one-read/one-write age memory at the transfer
// edge, the choice and the age update are made in the next cycle, and the
// result is registered at the end of that cycle. The receiver cannot stall; a
// result that is not taken in its cycle is gone. Back-to-back commands to the
// same set see each other's updates through a forwarding register. After
// reset, busy stays high while a sweep writes the initial age permutation
// (way w has age w) into every set. dirty_threshold is written through
// cfg_we_i/cfg_wdata_i and resets to 8.
module dirty_aware_lru_victim_select_unit
  import dalru_pkg::*;
#(
  parameter int WAYS = 8,
  parameter int SETS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  item_t              item_i,
  input  logic               cfg_we_i,
  input  logic [ThreshW-1:0] cfg_wdata_i,
  output logic               result_valid_o,
  output result_t            result_o
);

  localparam int AgeW = $clog2(WAYS);
  localparam int RowW = WAYS * AgeW;
  localparam int SetW = (SETS > 1) ? $clog2(SETS) : 1;

  logic               accept;
  logic               clearing;
  logic [RowW-1:0]    init_row;
  logic [SetIdxW-1:0] red_set;
  logic [RowW-1:0]    rd_row, cur_row, new_row;
  result_t            sel_res;

  logic [ThreshW-1:0] thr_q;
  logic               s1_valid_q;
  item_t              s1_item_q;
  logic [SetIdxW-1:0] s1_set_q;
  logic               fwd_q, fwd_d;
  logic [RowW-1:0]    fwd_row_q;
  logic               res_valid_q, res_valid_d;
  result_t            res_q;

  assign accept = start & ~busy;
  assign busy   = clearing;

  for (genvar w = 0; w < WAYS; w++) begin : g_init
    assign init_row[w*AgeW +: AgeW] = AgeW'(w);
  end

  // set index modulo SETS: restoring reduction, one shifted compare per bit
  always_comb begin
    red_set = item_i.set_index;
    for (int k = SetIdxW - 1; k >= 0; k--) begin
      if (int'(red_set) >= (SETS << k)) begin
        red_set = red_set - SetIdxW'(SETS << k);
      end
    end
  end

  dalru_age_mem #(
    .SETS  (SETS),
    .ROW_W (RowW)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_row_i (init_row),
    .rd_addr_i  (SetW'(red_set)),
    .rd_data_o  (rd_row),
    .wr_en_i    (s1_valid_q),
    .wr_addr_i  (SetW'(s1_set_q)),
    .wr_data_i  (new_row),
    .clearing_o (clearing)
  );

  // memory read returns old data when the previous command wrote the same set
  assign cur_row = fwd_q ? fwd_row_q : rd_row;

  dalru_select #(
    .WAYS (WAYS)
  ) u_sel (
    .item_i   (s1_item_q),
    .set_i    (s1_set_q),
    .thresh_i (thr_q),
    .ages_i   (cur_row),
    .result_o (sel_res),
    .ages_o   (new_row)
  );

  assign fwd_d       = s1_valid_q && accept && (red_set == s1_set_q);
  assign res_valid_d = s1_valid_q && (s1_item_q.command == CMD_VICTIM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= ThreshReset;
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      s1_valid_q  <= accept;
      fwd_q       <= fwd_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= item_i;
      s1_set_q  <= red_set;
    end
    fwd_row_q <= new_row;
    res_q     <= sel_res;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // a result only follows a victim command in the select stage
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(s1_valid_q && (s1_item_q.command == CMD_VICTIM)))
    else $error("result without victim command");

  // nothing enters the select stage while the age sweep runs
  a_no_work_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(!clearing))
    else $error("command taken during clearing sweep");

  // the threshold path reports the oldest way and leaves the ages alone
  a_thr_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && sel_res.threshold_event) |-> (new_row == cur_row))
    else $error("threshold eviction changed the ages");

  // reported set is always a reduced index
  a_set_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (int'(res_q.event_set) < SETS))
    else $error("event set out of range");

endmodule
